// ----- rtl/ihex_pkg.sv -----
// Shared types, character codes and helpers for the Intel HEX record parser.
// No dependencies.
package ihex_pkg;

  localparam logic [7:0] CHAR_COLON    = 8'h3A;
  localparam logic [7:0] CHAR_LF       = 8'h0A;
  localparam logic [7:0] REC_TYPE_DATA = 8'h00;
  localparam logic [7:0] REC_TYPE_EOF  = 8'h01;
  // Characters in a record besides the data digits: count, address, type,
  // checksum (ten digits) and the terminator.
  localparam logic [9:0] FRAME_OVERHEAD = 10'd11;
  localparam logic [15:0] MIN_ADDR_RESET = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_LENGTH   = 2'd1,
    ERR_HEX      = 2'd2,
    ERR_CHECKSUM = 2'd3
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [16:0] address;
    logic [7:0]  data_byte;
    err_e        error_code;
    logic [15:0] low_address;
    logic [16:0] high_address;
    logic [16:0] image_size;
  } result_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] value;
  } hex_digit_t;

  // Decode one ASCII hex digit; flag anything that is not 0-9, A-F or a-f.
  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    r.bad   = 1'b0;
    r.value = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r.value = 4'(c - 8'h30);
    end else if (c inside {[8'h41:8'h46]}) begin
      r.value = 4'(c - 8'h37);
    end else if (c inside {[8'h61:8'h66]}) begin
      r.value = 4'(c - 8'h57);
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

// ----- rtl/intel_hex_record_parser.sv -----
// Intel HEX record parser: character stream in, byte writes, summary or error out.
// Depends on ihex_pkg.
//
// The parser takes one character beat per clock cycle and never needs more: each
// character updates the record state (position, count, address, type, running
// checksum, address bounds) through one short step of logic, and any result it
// causes is captured in an output register in the same cycle. Behind that register
// sits one skid register, so input keeps flowing while a result waits; in_ready_o
// falls only when both hold results, and rises again the cycle after the sink takes
// one. A record opens at ':' and closes at LF; it must be exactly 2n+13 characters
// long, the last before LF being a terminator of any value (normally CR). Each data byte of a
// type 0 record gives one write as soon as its second digit arrives. A type 1
// record, or end_of_input outside a record, gives a summary of the lowest data record
// start address, the highest byte address written and the image size (zero when no
// data was seen). The first error or summary stops the parser: later beats are
// accepted and dropped until reset. Reset is immediate; there is no clearing pass.
module intel_hex_record_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [16:0] address_o,
  output logic [7:0]  data_byte_o,
  output logic [1:0]  error_code_o,
  output logic [15:0] low_address_o,
  output logic [16:0] high_address_o,
  output logic [16:0] image_size_o
);
  import ihex_pkg::*;

  // Parse state
  logic [9:0]  char_pos_q, char_pos_d;
  logic        in_record_q, in_record_d;
  logic [7:0]  byte_count_q, byte_count_d;
  logic [15:0] rec_addr_q, rec_addr_d;
  logic [7:0]  rec_type_q, rec_type_d;
  logic [7:0]  sum_q, sum_d;
  logic [3:0]  high_nib_q, high_nib_d;
  logic [15:0] min_addr_q, min_addr_d;
  logic [16:0] max_addr_q, max_addr_d;
  logic        saw_data_q, saw_data_d;
  logic        stopped_q, stopped_d;

  // Output register pair
  result_t     main_q, main_d, skid_q, skid_d;
  logic        main_valid_q, main_valid_d, skid_valid_q, skid_valid_d;

  logic        accept, pop;
  logic [9:0]  limit;
  logic [8:0]  byte_idx;
  logic [7:0]  byte_val;
  logic [16:0] wr_addr;
  hex_digit_t  digit;
  logic        do_write, do_error, do_summary;
  err_e        err_code;
  result_t     res;

  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign pop        = main_valid_q && out_ready_i;

  // Position of the LF that closes the record: 2n+11.
  assign limit    = {1'b0, byte_count_q, 1'b0} + FRAME_OVERHEAD;
  assign byte_idx = char_pos_q[9:1];
  assign digit    = hex_decode(char_code_i);
  assign byte_val = {high_nib_q, digit.value};
  assign wr_addr  = {1'b0, rec_addr_q} + 17'(byte_idx - 9'd4);

  always_comb begin
    char_pos_d   = char_pos_q;
    in_record_d  = in_record_q;
    byte_count_d = byte_count_q;
    rec_addr_d   = rec_addr_q;
    rec_type_d   = rec_type_q;
    sum_d        = sum_q;
    high_nib_d   = high_nib_q;
    min_addr_d   = min_addr_q;
    max_addr_d   = max_addr_q;
    saw_data_d   = saw_data_q;
    stopped_d    = stopped_q;
    do_write     = 1'b0;
    do_error     = 1'b0;
    do_summary   = 1'b0;
    err_code     = ERR_NONE;

    if (accept && !stopped_q) begin
      if (!in_record_q) begin
        // Skip everything outside a record until its start mark.
        if (char_code_i == CHAR_COLON) begin
          in_record_d  = 1'b1;
          char_pos_d   = '0;
          byte_count_d = '0;
          rec_addr_d   = '0;
          rec_type_d   = '0;
          sum_d        = '0;
          high_nib_d   = '0;
        end
      end else if (char_code_i == CHAR_LF) begin
        // Close the record: length, then checksum, then end-of-file type.
        if (char_pos_q < 10'd2 || char_pos_q != limit) begin
          do_error = 1'b1;
          err_code = ERR_LENGTH;
        end else if (sum_q != 8'd0) begin
          do_error = 1'b1;
          err_code = ERR_CHECKSUM;
        end else if (rec_type_q == REC_TYPE_EOF) begin
          do_summary = 1'b1;
        end else begin
          in_record_d = 1'b0;
        end
      end else if (char_pos_q >= 10'd2 && char_pos_q >= limit) begin
        // Past the terminator without a line feed.
        do_error = 1'b1;
        err_code = ERR_LENGTH;
      end else if (char_pos_q >= 10'd2 && char_pos_q == limit - 10'd1) begin
        // Terminator slot: any character will do.
        char_pos_d = char_pos_q + 10'd1;
      end else if (digit.bad) begin
        do_error = 1'b1;
        err_code = ERR_HEX;
      end else begin
        char_pos_d = char_pos_q + 10'd1;
        if (!char_pos_q[0]) begin
          high_nib_d = digit.value;
        end else begin
          sum_d = sum_q + byte_val;
          case (byte_idx)
            9'd0: byte_count_d = byte_val;
            9'd1: rec_addr_d   = {byte_val, 8'd0};
            9'd2: rec_addr_d   = {rec_addr_q[15:8], byte_val};
            9'd3: begin
              rec_type_d = byte_val;
              if (byte_val == REC_TYPE_DATA && rec_addr_q < min_addr_q) begin
                min_addr_d = rec_addr_q;
              end
            end
            default: begin
              if ({1'b0, byte_idx} < {2'b00, byte_count_q} + 10'd4 &&
                  rec_type_q == REC_TYPE_DATA) begin
                do_write   = 1'b1;
                saw_data_d = 1'b1;
                if (wr_addr > max_addr_q) begin
                  max_addr_d = wr_addr;
                end
              end
            end
          endcase
        end
      end

      // End of input: an open record is a length fault, else finish.
      if (end_of_input_i && !do_error && !do_summary) begin
        do_write = 1'b0;
        if (in_record_d) begin
          do_error = 1'b1;
          err_code = ERR_LENGTH;
        end else begin
          do_summary = 1'b1;
        end
      end

      if (do_error || do_summary) begin
        stopped_d   = 1'b1;
        in_record_d = 1'b0;
      end
    end
  end

  // Assemble the result beat for this character.
  always_comb begin
    res = '0;
    if (do_error) begin
      res.kind       = KIND_ERROR;
      res.error_code = err_code;
    end else if (do_summary) begin
      res.kind         = KIND_SUMMARY;
      res.low_address  = min_addr_d;
      res.high_address = max_addr_d;
      res.image_size   = saw_data_d ? (max_addr_d - {1'b0, min_addr_d} + 17'd1) : 17'd0;
    end else begin
      res.kind      = KIND_WRITE;
      res.address   = wr_addr;
      res.data_byte = byte_val;
    end
  end

  // Output register with skid: hold the older beat in main, spill into skid.
  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        main_valid_d = do_write || do_error || do_summary;
        main_d       = res;
      end
    end else if (do_write || do_error || do_summary) begin
      if (main_valid_q) begin
        skid_valid_d = 1'b1;
        skid_d       = res;
      end else begin
        main_valid_d = 1'b1;
        main_d       = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_pos_q   <= '0;
      in_record_q  <= 1'b0;
      byte_count_q <= '0;
      rec_addr_q   <= '0;
      rec_type_q   <= '0;
      sum_q        <= '0;
      high_nib_q   <= '0;
      min_addr_q   <= MIN_ADDR_RESET;
      max_addr_q   <= '0;
      saw_data_q   <= 1'b0;
      stopped_q    <= 1'b0;
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      char_pos_q   <= char_pos_d;
      in_record_q  <= in_record_d;
      byte_count_q <= byte_count_d;
      rec_addr_q   <= rec_addr_d;
      rec_type_q   <= rec_type_d;
      sum_q        <= sum_d;
      high_nib_q   <= high_nib_d;
      min_addr_q   <= min_addr_d;
      max_addr_q   <= max_addr_d;
      saw_data_q   <= saw_data_d;
      stopped_q    <= stopped_d;
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign out_valid_o    = main_valid_q;
  assign kind_o         = main_q.kind;
  assign address_o      = main_q.address;
  assign data_byte_o    = main_q.data_byte;
  assign error_code_o   = main_q.error_code;
  assign low_address_o  = main_q.low_address;
  assign high_address_o = main_q.high_address;
  assign image_size_o   = main_q.image_size;

  // The skid register only ever fills behind a waiting main beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid register holds a beat while main is empty");

  // A stop lasts until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |=> stopped_q)
    else $error("parser left the stopped state without reset");

  // A stopped parser has no open record and makes no new results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> !in_record_q && !do_write && !do_error && !do_summary)
    else $error("stopped parser is still producing results");

  // An open record never runs past its closing line feed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_record_q |-> char_pos_q <= limit)
    else $error("record position beyond its terminator");

  // Writes come only from inside a data record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_write |-> in_record_q && rec_type_q == REC_TYPE_DATA && !end_of_input_i)
    else $error("byte write outside a data record");

endmodule
